[rtl/ffo_pkg.sv]
package ffo_pkg;

	localparam int DEPTH  = 256;
	localparam int DATA_W = 32;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW     = $clog2(DEPTH + 1);
	localparam int SW     = CW + 1;
	localparam int OP_W   = 3;
	localparam int VAL_W  = 32;
	localparam int NUM_W  = 9;
	localparam int STAT_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH   = 3'd0,
		OP_POP    = 3'd1,
		OP_SIZE   = 3'd2,
		OP_CLEAR  = 3'd3,
		OP_COUNT  = 3'd4,
		OP_REMOVE = 3'd5,
		OP_INSERT = 3'd6
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic              we;
		logic [AW-1:0]     waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [AW-1:0]     raddr;
	} mem_req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] data_out;
		logic [NUM_W-1:0]        number;
		status_t                 status;
	} res_t;

	// slot index a + b modulo DEPTH; a < DEPTH, b <= DEPTH
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
		logic [SW-1:0] s;
		s = SW'(a) + SW'(b);
		if (s >= SW'(DEPTH)) begin
			s = s - SW'(DEPTH);
		end
		return AW'(s);
	endfunction

endpackage

[rtl/ffo_if.sv]
interface ffo_req_if;
	logic                           valid;
	logic                           ready;
	logic [ffo_pkg::OP_W-1:0]       op;
	logic signed [ffo_pkg::VAL_W-1:0] value;

	modport source(output valid, output op, output value, input ready);
	modport sink(input valid, input op, input value, output ready);
endinterface

interface ffo_rsp_if;
	logic                              valid;
	logic                              ready;
	logic signed [ffo_pkg::VAL_W-1:0]  data_out;
	logic [ffo_pkg::NUM_W-1:0]         number;
	logic [ffo_pkg::STAT_W-1:0]        status;

	modport source(output valid, output data_out, output number, output status, input ready);
	modport sink(input valid, input data_out, input number, input status, output ready);
endinterface

[rtl/ffo_ram.sv]
module ffo_ram (
	input  logic                       clk,
	input  ffo_pkg::mem_req_t          mem_req,
	output logic [ffo_pkg::DATA_W-1:0] rdata
);

	logic [ffo_pkg::DATA_W-1:0] mem [ffo_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (mem_req.we) begin
			mem[mem_req.waddr] <= mem_req.wdata;
		end
		if (mem_req.re) begin
			rdata <= mem[mem_req.raddr];
		end
	end

endmodule

[rtl/ffo_ctrl.sv]
module ffo_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	ffo_req_if.sink                    req,
	input  logic                       out_free,
	input  logic [ffo_pkg::DATA_W-1:0] rdata,
	output ffo_pkg::mem_req_t          mem_req,
	output logic                       res_valid,
	output ffo_pkg::res_t              res
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_POP  = 6'b000010,
		S_RD   = 6'b000100,
		S_PROC = 6'b001000,
		S_INS  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t                     state_q;
	ffo_pkg::op_t               op_q;
	ffo_pkg::op_t               op_in;
	logic [ffo_pkg::AW-1:0]     head_q;
	logic [ffo_pkg::AW-1:0]     tail_q;
	logic [ffo_pkg::CW-1:0]     occ_q;
	logic [ffo_pkg::CW-1:0]     k_q;
	logic [ffo_pkg::CW-1:0]     n_q;
	logic [ffo_pkg::CW-1:0]     w_q;
	logic                       phase_q;
	logic [ffo_pkg::DATA_W-1:0] val_q;
	ffo_pkg::res_t              res_q;
	logic                       accept;
	logic                       walk_end;
	logic                       neg;
	logic [ffo_pkg::SW-1:0]     ins_total;

	assign op_in     = ffo_pkg::op_t'(req.op);
	assign req.ready = (state_q == S_IDLE) || ((state_q == S_DONE) && out_free);
	assign accept    = req.valid && req.ready;
	assign walk_end  = phase_q ? (k_q == '0) : (k_q == occ_q);
	assign neg       = rdata[ffo_pkg::DATA_W-1];
	assign ins_total = ffo_pkg::SW'(occ_q) + ffo_pkg::SW'(n_q);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	always_comb begin
		mem_req = '0;
		if (accept && (op_in == ffo_pkg::OP_PUSH) && (occ_q != ffo_pkg::CW'(ffo_pkg::DEPTH))) begin
			mem_req.we    = 1'b1;
			mem_req.waddr = tail_q;
			mem_req.wdata = ffo_pkg::DATA_W'(req.value);
		end
		if (accept && (op_in == ffo_pkg::OP_POP) && (occ_q != '0)) begin
			mem_req.re    = 1'b1;
			mem_req.raddr = head_q;
		end
		case (state_q)
			S_RD: begin
				if (!walk_end) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = phase_q ?
						ffo_pkg::wrap_add(head_q, k_q - ffo_pkg::CW'(1)) :
						ffo_pkg::wrap_add(head_q, k_q);
				end
			end
			S_PROC: begin
				if ((op_q == ffo_pkg::OP_REMOVE) && !neg) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = ffo_pkg::wrap_add(head_q, n_q);
					mem_req.wdata = rdata;
				end
				if ((op_q == ffo_pkg::OP_INSERT) && phase_q) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = ffo_pkg::wrap_add(head_q, w_q - ffo_pkg::CW'(1));
					mem_req.wdata = rdata;
				end
			end
			S_INS: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = ffo_pkg::wrap_add(head_q, w_q - ffo_pkg::CW'(1));
				mem_req.wdata = ffo_pkg::DATA_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q           <= op_in;
			val_q          <= ffo_pkg::DATA_W'(req.value);
			k_q            <= '0;
			n_q            <= '0;
			res_q.data_out <= '0;
			res_q.status   <= ffo_pkg::ST_OK;
			res_q.number   <= ffo_pkg::NUM_W'(occ_q);
			case (op_in)
				ffo_pkg::OP_PUSH: begin
					if (occ_q == ffo_pkg::CW'(ffo_pkg::DEPTH)) begin
						res_q.status <= ffo_pkg::ST_FULL;
					end else begin
						res_q.number <= ffo_pkg::NUM_W'(occ_q + ffo_pkg::CW'(1));
					end
				end
				ffo_pkg::OP_POP: begin
					if (occ_q == '0) begin
						res_q.status <= ffo_pkg::ST_EMPTY;
					end else begin
						res_q.number <= ffo_pkg::NUM_W'(occ_q - ffo_pkg::CW'(1));
					end
				end
				ffo_pkg::OP_CLEAR: begin
					res_q.number <= '0;
				end
				default: begin
				end
			endcase
		end else begin
			case (state_q)
				S_POP: begin
					res_q.data_out <= rdata;
				end
				S_RD: begin
					if (walk_end) begin
						case (op_q)
							ffo_pkg::OP_COUNT, ffo_pkg::OP_REMOVE: begin
								res_q.number <= ffo_pkg::NUM_W'(n_q);
							end
							ffo_pkg::OP_INSERT: begin
								if (phase_q) begin
									res_q.number <= ffo_pkg::NUM_W'(n_q);
								end else if (ins_total > ffo_pkg::SW'(ffo_pkg::DEPTH)) begin
									res_q.status <= ffo_pkg::ST_FULL;
								end else begin
									k_q <= occ_q;
									w_q <= ffo_pkg::CW'(ins_total);
									n_q <= ffo_pkg::CW'(ins_total);
								end
							end
							default: begin
							end
						endcase
					end else if (phase_q) begin
						k_q <= k_q - ffo_pkg::CW'(1);
					end
				end
				S_PROC: begin
					if (phase_q) begin
						w_q <= w_q - ffo_pkg::CW'(1);
					end else begin
						k_q <= k_q + ffo_pkg::CW'(1);
						case (op_q)
							ffo_pkg::OP_COUNT: begin
								if (rdata == val_q) begin
									n_q <= n_q + ffo_pkg::CW'(1);
								end
							end
							ffo_pkg::OP_REMOVE: begin
								if (!neg) begin
									n_q <= n_q + ffo_pkg::CW'(1);
								end
							end
							default: begin
								if (neg) begin
									n_q <= n_q + ffo_pkg::CW'(1);
								end
							end
						endcase
					end
				end
				S_INS: begin
					w_q <= w_q - ffo_pkg::CW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			occ_q   <= '0;
			phase_q <= 1'b0;
		end else if (accept) begin
			phase_q <= 1'b0;
			state_q <= S_DONE;
			case (op_in)
				ffo_pkg::OP_PUSH: begin
					if (occ_q != ffo_pkg::CW'(ffo_pkg::DEPTH)) begin
						tail_q <= ffo_pkg::wrap_add(tail_q, ffo_pkg::CW'(1));
						occ_q  <= occ_q + ffo_pkg::CW'(1);
					end
				end
				ffo_pkg::OP_POP: begin
					if (occ_q != '0) begin
						head_q  <= ffo_pkg::wrap_add(head_q, ffo_pkg::CW'(1));
						occ_q   <= occ_q - ffo_pkg::CW'(1);
						state_q <= S_POP;
					end
				end
				ffo_pkg::OP_CLEAR: begin
					head_q <= '0;
					tail_q <= '0;
					occ_q  <= '0;
				end
				ffo_pkg::OP_COUNT, ffo_pkg::OP_REMOVE, ffo_pkg::OP_INSERT: begin
					state_q <= S_RD;
				end
				default: begin
				end
			endcase
		end else begin
			case (state_q)
				S_POP: begin
					state_q <= S_DONE;
				end
				S_RD: begin
					if (walk_end) begin
						state_q <= S_DONE;
						case (op_q)
							ffo_pkg::OP_REMOVE: begin
								occ_q  <= n_q;
								tail_q <= ffo_pkg::wrap_add(head_q, n_q);
							end
							ffo_pkg::OP_INSERT: begin
								if (phase_q) begin
									occ_q  <= n_q;
									tail_q <= ffo_pkg::wrap_add(head_q, n_q);
								end else if (ins_total <= ffo_pkg::SW'(ffo_pkg::DEPTH)) begin
									phase_q <= 1'b1;
									state_q <= S_RD;
								end
							end
							default: begin
							end
						endcase
					end else begin
						state_q <= S_PROC;
					end
				end
				S_PROC: begin
					state_q <= (phase_q && neg) ? S_INS : S_RD;
				end
				S_INS: begin
					state_q <= S_RD;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/fifo_with_filter_ops.sv]
// Sequencing: push, size and clear results pass from the controller's result register into
// the output register; pop adds one memory read (S_POP). Count and remove walk each entry
// once; insert makes a counting pass, then (unless it overflows) a moving pass that writes 1
// before each negative (S_INS). Each entry is read (S_RD) then processed (S_PROC) on the entry
// memory. Push, size and clear sustain one transaction per cycle while rsp is not stalled.
// Reset clears pointers, occupancy and control; entry memory contents are not cleared.
module fifo_with_filter_ops (
	input  logic      clk,
	input  logic      arst_n,
	ffo_req_if.sink   req,
	ffo_rsp_if.source rsp
);

	ffo_pkg::mem_req_t          mem_req;
	logic [ffo_pkg::DATA_W-1:0] rdata;
	ffo_pkg::res_t              res;
	logic                       res_valid;
	logic                       out_free;
	logic                       out_valid_q;
	ffo_pkg::res_t              out_q;

	assign out_free     = !out_valid_q || rsp.ready;
	assign rsp.valid    = out_valid_q;
	assign rsp.data_out = out_q.data_out;
	assign rsp.number   = out_q.number;
	assign rsp.status   = out_q.status;

	ffo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.out_free  (out_free),
		.rdata     (rdata),
		.mem_req   (mem_req),
		.res_valid (res_valid),
		.res       (res)
	);

	ffo_ram u_ram (
		.clk     (clk),
		.mem_req (mem_req),
		.rdata   (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && out_free) begin
			out_q <= res;
		end
	end

endmodule

[test/fifo_with_filter_ops_test.sv]
module fifo_with_filter_ops_test;
	import ffo_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
	localparam int WATCHDOG_LIMIT = 6000;
	localparam int ITEM_TARGET    = 1850;
	localparam int CALM_ITEMS     = 200;
	localparam int DRAIN_CYCLES   = 20;

	class ffo_scoreboard;
		logic [DATA_W-1:0] slots [DEPTH];
		logic [AW-1:0]     head;
		logic [AW-1:0]     tail;
		int unsigned       fill;
		res_t              pending_results [$];
		int unsigned       errors;
		int unsigned       results_seen;

		function new();
			head = '0;
			tail = '0;
			fill = 0;
			errors = 0;
			results_seen = 0;
		endfunction

		function int unsigned pending();
			return pending_results.size();
		endfunction

		function logic [DATA_W-1:0] entry_at(int unsigned k);
			return slots[(int'(head) + k) % DEPTH];
		endfunction

		function bit neg_at(int unsigned k);
			logic [DATA_W-1:0] e;
			e = entry_at(k);
			return e[DATA_W-1];
		endfunction

		function int unsigned negatives();
			int unsigned n;
			n = 0;
			for (int unsigned k = 0; k < fill; k++) begin
				if (neg_at(k)) begin
					n++;
				end
			end
			return n;
		endfunction

		function void rewrite(logic [DATA_W-1:0] words [$]);
			foreach (words[k]) begin
				slots[(int'(head) + k) % DEPTH] = words[k];
			end
			fill = words.size();
			tail = AW'((int'(head) + fill) % DEPTH);
		endfunction

		// accepted request: advance the queue state, queue the expected response
		function void note(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] value);
			res_t              r;
			logic [DATA_W-1:0] word;
			logic [DATA_W-1:0] words [$];
			int unsigned       n;
			word = DATA_W'(value);
			r.data_out = '0;
			r.status = ST_OK;
			n = 0;
			case (op)
				OP_PUSH: begin
					if (fill >= DEPTH) begin
						r.status = ST_FULL;
					end else begin
						slots[tail] = word;
						tail = AW'((int'(tail) + 1) % DEPTH);
						fill++;
					end
				end
				OP_POP: begin
					if (fill == 0) begin
						r.status = ST_EMPTY;
					end else begin
						r.data_out = slots[head];
						head = AW'((int'(head) + 1) % DEPTH);
						fill--;
					end
				end
				OP_CLEAR: begin
					head = '0;
					tail = '0;
					fill = 0;
				end
				OP_COUNT: begin
					for (int unsigned k = 0; k < fill; k++) begin
						if (entry_at(k) == word) begin
							n++;
						end
					end
				end
				OP_REMOVE: begin
					for (int unsigned k = 0; k < fill; k++) begin
						if (!neg_at(k)) begin
							words.push_back(entry_at(k));
						end
					end
					rewrite(words);
				end
				OP_INSERT: begin
					if (fill + negatives() > DEPTH) begin
						r.status = ST_FULL;
					end else begin
						for (int unsigned k = 0; k < fill; k++) begin
							if (neg_at(k)) begin
								words.push_back(DATA_W'(1));
							end
							words.push_back(entry_at(k));
						end
						rewrite(words);
					end
				end
				default: begin
				end
			endcase
			r.number = (op == OP_COUNT) ? NUM_W'(n) : NUM_W'(fill);
			pending_results.push_back(r);
		endfunction

		task report(string msg);
			errors++;
			$display("ERROR: %s", msg);
		endtask

		task check(logic signed [VAL_W-1:0] data_out, logic [NUM_W-1:0] number,
			logic [STAT_W-1:0] status);
			res_t want;
			if (pending_results.size() == 0) begin
				report($sformatf("response with nothing outstanding: data_out %0h number %0d",
					data_out, number));
				return;
			end
			want = pending_results.pop_front();
			if (data_out !== want.data_out) begin
				report($sformatf("response %0d data_out %0h, expected %0h", results_seen,
					data_out, want.data_out));
			end
			if (number !== want.number) begin
				report($sformatf("response %0d number %0d, expected %0d", results_seen,
					number, want.number));
			end
			if (status !== want.status) begin
				report($sformatf("response %0d status %0d, expected %0d", results_seen,
					status, want.status));
			end
			results_seen++;
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ffo_req_if req_ch();
	ffo_rsp_if rsp_ch();

	fifo_with_filter_ops dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	ffo_scoreboard sb = new();

	logic signed [VAL_W-1:0] pool [8];
	bit          calm = 1'b0;
	int unsigned sent = 0;
	int          gap_pct = 0;
	int          ready_gap_pct = 0;
	int          stall_left = 0;
	int          quiet_cycles = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (!arst_n || calm) begin
			rsp_ch.ready <= 1'b1;
		end else if (stall_left != 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 99) < ready_gap_pct) begin
			rsp_ch.ready <= 1'b0;
			stall_left <= $urandom_range(0, 7);
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				sb.check(rsp_ch.data_out, rsp_ch.number, rsp_ch.status);
			end
			if ((req_ch.valid && req_ch.ready === 1'b1) ||
				(rsp_ch.valid === 1'b1 && rsp_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	function automatic logic signed [VAL_W-1:0] pick_word(int neg_pct);
		logic [VAL_W-1:0] w;
		if ($urandom_range(0, 3) == 0) begin
			return pool[$urandom_range(0, 7)];
		end
		w = $urandom;
		w[VAL_W-1] = ($urandom_range(0, 99) < neg_pct);
		return w;
	endfunction

	// match value for a count: often a stored entry so counts are nonzero
	function automatic logic signed [VAL_W-1:0] pick_match();
		if (sb.fill != 0 && $urandom_range(0, 1) == 0) begin
			return sb.entry_at($urandom_range(0, sb.fill - 1));
		end
		return pick_word(50);
	endfunction

	// called and returns at a falling edge
	task automatic send(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] value);
		if (!calm && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.value <= value;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		sb.note(op, value);
		sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	task automatic shallow_run(int unsigned target, int len, int neg_pct);
		int r;
		repeat (len) begin
			r = $urandom_range(0, 99);
			if (r < 5) begin
				send(OP_COUNT, pick_match());
			end else if (r < 9) begin
				send(OP_REMOVE, $urandom);
			end else if (r < 13) begin
				send(OP_INSERT, $urandom);
			end else if (r < 16) begin
				send(OP_SIZE, $urandom);
			end else if (r < 18) begin
				send(OP_CLEAR, $urandom);
			end else if (r < 20) begin
				send(OP_UNUSED, $urandom);
			end else if ($urandom_range(0, 99) < ((sb.fill < target) ? 70 : 30)) begin
				send(OP_PUSH, pick_word(neg_pct));
			end else begin
				send(OP_POP, $urandom);
			end
		end
	endtask

	task automatic deep_run(int neg_pct);
		bit tried;
		tried = 1'b0;
		while (sb.fill < DEPTH) begin
			// try an insert right at the capacity boundary once
			if (!tried && sb.fill + sb.negatives() >= DEPTH &&
				sb.fill + sb.negatives() <= DEPTH + 1 && sb.negatives() != 0) begin
				send(OP_INSERT, $urandom);
				tried = 1'b1;
			end else begin
				case ($urandom_range(0, 24))
					0: send(OP_POP, $urandom);
					1: send(OP_SIZE, $urandom);
					2: send(OP_UNUSED, $urandom);
					default: send(OP_PUSH, pick_word(neg_pct));
				endcase
			end
		end
		send(OP_PUSH, pick_word(neg_pct));
		send(OP_COUNT, pick_match());
		send(OP_INSERT, $urandom);
		wait_drained();
		case ($urandom_range(0, 2))
			0: send(OP_CLEAR, $urandom);
			1: begin
				send(OP_REMOVE, $urandom);
				while (sb.fill > 16) send(OP_POP, $urandom);
			end
			default: begin
				while (sb.fill > 16) send(OP_POP, $urandom);
			end
		endcase
	endtask

	initial begin
		int  seg;
		bit  deep;
		req_ch.valid = 1'b0;
		req_ch.op = OP_PUSH;
		req_ch.value = '0;
		rsp_ch.ready = 1'b0;
		pool[0] = 32'sh8000_0000;
		pool[1] = 32'sh7fff_ffff;
		pool[2] = 32'sh0;
		pool[3] = -32'sd1;
		pool[4] = 32'sd1;
		pool[5] = -32'sd2;
		pool[6] = $urandom;
		pool[7] = $urandom | 32'h8000_0000;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send(OP_POP, $urandom);
		send(OP_SIZE, $urandom);
		send(OP_COUNT, 32'sh0);
		send(OP_REMOVE, $urandom);
		send(OP_INSERT, $urandom);
		send(OP_PUSH, 32'sh7fff_ffff);
		send(OP_PUSH, 32'sh8000_0000);
		send(OP_PUSH, -32'sd1);
		send(OP_PUSH, 32'sh0);
		send(OP_PUSH, 32'sd1);
		send(OP_PUSH, 32'sh8000_0000);
		send(OP_COUNT, 32'sh8000_0000);
		send(OP_UNUSED, $urandom);
		send(OP_INSERT, $urandom);
		send(OP_COUNT, 32'sd1);
		send(OP_REMOVE, $urandom);
		send(OP_SIZE, $urandom);
		send(OP_POP, $urandom);
		send(OP_POP, $urandom);
		send(OP_CLEAR, $urandom);
		send(OP_POP, $urandom);
		send(OP_PUSH, -32'sd5);
		send(OP_POP, $urandom);

		seg = 0;
		while (sent < ITEM_TARGET) begin
			if (!calm && ITEM_TARGET - sent <= CALM_ITEMS) begin
				calm = 1'b1;
				gap_pct = 0;
				ready_gap_pct = 0;
			end
			if (!calm) begin
				gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
				ready_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
			end
			deep = !calm && (ITEM_TARGET - sent > 3 * CALM_ITEMS) &&
				(seg == 1 || seg == 6 || $urandom_range(0, 11) == 0);
			if (deep) begin
				deep_run((seg == 1) ? 70 : (seg == 6) ? 0 : $urandom_range(0, 100));
			end else begin
				shallow_run($urandom_range(0, 24), $urandom_range(20, 60),
					$urandom_range(0, 100));
			end
			seg++;
		end

		req_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
